### src/gpps_pkg.sv
// Package with the shared types, constants and elaboration-time tables of the position sampler.
package gpps_pkg;

	// Profile modes; the spare code behaves as the single profile.
	typedef enum logic [1:0] {
		MODE_SINGLE = 2'd0,
		MODE_DOUBLE = 2'd1,
		MODE_XDEP   = 2'd2
	} mode_t;

	// Configuration register indexes.
	typedef enum logic [2:0] {
		REG_MODE       = 3'd0,
		REG_RADIUS_ONE = 3'd1,
		REG_RADIUS_TWO = 3'd2,
		REG_FRACTION   = 3'd3,
		REG_EXPONENT   = 3'd4
	} reg_idx_t;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;
	localparam int POS_W      = 25;

	localparam logic [31:0]        LN2_Q32 = 32'd2977044472;
	localparam logic [24:0]        X_FLOOR = 25'd17;
	localparam logic signed [31:0] ONE_Q30 = 32'sd1073741824;
	localparam logic [31:0]        Q20_CAP = 32'hFFFF_FFFF;
	localparam logic signed [30:0] POS_MAX = 31'sd16777215;
	localparam logic signed [30:0] POS_MIN = -31'sd16777216;

	// One result item as it leaves the pipeline.
	typedef struct packed {
		logic signed [POS_W-1:0] pos_x;
		logic signed [POS_W-1:0] pos_y;
		logic                    saturated;
	} result_t;

	// Floor square root, used only while elaborating the constant tables.
	function automatic logic [63:0] isqrt_c(input logic [63:0] v_in);
		logic [63:0] v;
		logic [63:0] r;
		logic [63:0] bt;
		v  = v_in;
		r  = '0;
		bt = 64'h4000_0000_0000_0000;
		for (int j = 0; j < 32; j++) begin
			if (v >= r + bt) begin
				v = v - (r + bt);
				r = (r >> 1) + bt;
			end else begin
				r = r >> 1;
			end
			bt = bt >> 2;
		end
		return r;
	endfunction

	// Long division by shift and subtract, used only while elaborating the tables.
	function automatic logic [63:0] udiv_c(input logic [63:0] n, input logic [63:0] d);
		logic [63:0] q;
		logic [63:0] rem;
		q   = '0;
		rem = '0;
		for (int j = 63; j >= 0; j--) begin
			rem = {rem[62:0], n[j]};
			if (rem >= d) begin
				rem  = rem - d;
				q[j] = 1'b1;
			end
		end
		return q;
	endfunction

	// Factor 2^(2^-i) in Q1.31, built by i repeated square roots.
	function automatic logic [31:0] exp2_coef(input int i);
		logic [63:0] c;
		c = 64'h1_0000_0000;
		for (int j = 1; j <= 20; j++) begin
			if (j <= i) c = isqrt_c(c << 31);
		end
		return c[31:0];
	endfunction

	// Cosine (sel = 0) or sine (sel = 1) of 2*pi/2^i in Q30 by half-angle steps.
	function automatic logic [31:0] rot_coef(input int i, input logic sel);
		logic [63:0] wc;
		logic [63:0] ws;
		logic [63:0] cn;
		wc = '0;
		ws = 64'd1073741824;
		for (int j = 3; j <= 32; j++) begin
			if (j <= i) begin
				cn = isqrt_c((64'd1073741824 + wc) << 29);
				ws = udiv_c(ws << 29, cn);
				wc = cn;
			end
		end
		return sel ? ws[31:0] : wc[31:0];
	endfunction

	// Leading-one position and Q1.31 mantissa of m: {e, y}.
	function automatic logic [37:0] log2_norm(input logic [32:0] m);
		logic [5:0]  e;
		logic [63:0] w;
		e = '0;
		for (int j = 0; j < 33; j++) begin
			if (m[j]) e = 6'(j);
		end
		w = {31'b0, m};
		if (e <= 6'd31) w = w << (6'd31 - e);
		else w = w >> (e - 6'd31);
		return {e, w[31:0]};
	endfunction

	// One fraction bit of log2 by squaring the mantissa: {y, f}.
	function automatic logic [51:0] log2_step(input logic [31:0] y, input logic [19:0] f);
		logic [63:0] sq;
		logic [32:0] t;
		sq = {32'b0, y} * {32'b0, y};
		t  = sq[63:31];
		return t[32] ? {t[32:1], f[18:0], 1'b1} : {t[31:0], f[18:0], 1'b0};
	endfunction

	// Q30 product truncated toward zero.
	function automatic logic signed [31:0] mul_q30(input logic signed [31:0] a,
			input logic signed [31:0] b);
		logic signed [63:0] p;
		p = 64'(a) * 64'(b);
		if (p < 0) p = p + 64'sd1073741823;
		return 32'(p >>> 30);
	endfunction

	// Product divided by 2^34, truncated toward zero.
	function automatic logic signed [30:0] trunc34(input logic signed [64:0] p);
		logic signed [64:0] t;
		t = p;
		if (t < 0) t = t + 65'sd17179869183;
		return 31'(t >>> 34);
	endfunction

	// Clip to the position range: {clipped, value}.
	function automatic logic [POS_W:0] clip_pos(input logic signed [30:0] v);
		if (v > POS_MAX) return {1'b1, POS_MAX[POS_W-1:0]};
		if (v < POS_MIN) return {1'b1, POS_MIN[POS_W-1:0]};
		return {1'b0, v[POS_W-1:0]};
	endfunction

endpackage

### src/gpps_out_buf.sv
// Two-entry output buffer that parts the pipeline from the result channel.
module gpps_out_buf (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  gpps_pkg::result_t push_data,
	output logic              full,
	output logic              out_valid,
	input  logic              out_ready,
	output gpps_pkg::result_t out_data
);
	import gpps_pkg::*;

	logic [1:0] count_q;
	result_t    head_q;
	result_t    tail_q;
	logic       pop;

	assign pop       = out_valid && out_ready;
	assign out_valid = (count_q != 2'd0);
	assign out_data  = head_q;
	assign full      = (count_q == 2'd2);

	// Occupancy count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 2'd0;
		end else if (push && !pop) begin
			count_q <= count_q + 2'd1;
		end else if (pop && !push) begin
			count_q <= count_q - 2'd1;
		end
	end

	// Entry storage; the head always holds the oldest result.
	always_ff @(posedge clk) begin
		if (push && pop) begin
			if (count_q == 2'd1) begin
				head_q <= push_data;
			end else begin
				head_q <= tail_q;
				tail_q <= push_data;
			end
		end else if (pop) begin
			head_q <= tail_q;
		end else if (push) begin
			if (count_q == 2'd0) head_q <= push_data;
			else tail_q <= push_data;
		end
	end

endmodule

### src/gaussian_profile_position_sampler_unit.sv
// Top level of the Gaussian profile position sampler.
// Each input transfer yields one result transfer: a transverse position drawn from a 2D
// Gaussian profile, b = R*sqrt(-ln u) at angle 2*pi*u_phi, with pos_x and pos_y in fm as
// signed Q8.16 and a saturated flag in m_tuser. The block is a 48-stage pipeline that takes
// one item in every clock cycle while the output buffer has room; its stages hold the 20-step
// log2 squaring chain that is followed by the 23-step square root chain. A two-entry output
// buffer keeps accepting input while a result waits; when both entries are taken the whole
// pipeline holds. Configuration registers must only be written while no item is in flight.
module gaussian_profile_position_sampler_unit #(
	parameter int UNIFORM_BITS = 24
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [gpps_pkg::CFG_IDX_W-1:0]        cfg_idx,
	input  logic [gpps_pkg::CFG_DATA_W-1:0]       cfg_data,
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	// momentum_fraction, uniform_mix, uniform_radial, uniform_angle, zero fill
	input  logic [((26+3*UNIFORM_BITS+7)/8)*8-1:0] s_tdata,
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	// pos_x, pos_y, zero fill
	output logic [((2*gpps_pkg::POS_W+7)/8)*8-1:0] m_tdata,
	// saturated
	output logic                                  m_tuser
);
	import gpps_pkg::*;

	localparam int UB        = UNIFORM_BITS;
	localparam int DEPTH     = 48;
	localparam int LOG_LAST  = 20;
	localparam int K_PREP    = 21;
	localparam int K_SPLIT   = 22;
	localparam int EXP_FIRST = 23;
	localparam int EXP_LAST  = 42;
	localparam int K_PROD    = 43;
	localparam int K_RAD     = 44;
	localparam int SQ_FIRST  = 22;
	localparam int SQ_LAST   = 44;
	localparam int K_B       = 45;
	localparam int K_MUL     = 46;
	localparam int K_OUT     = 47;
	localparam int OUT_W     = ((2*POS_W+7)/8)*8;

	// Everything one item carries down the pipeline.
	typedef struct packed {
		logic                    x_ok;
		logic                    sel2;
		logic                    umax;
		logic [UB-1:0]           uang;
		logic [5:0]              lr_e;
		logic [31:0]             lr_y;
		logic [19:0]             lr_f;
		logic [5:0]              lx_e;
		logic [31:0]             lx_y;
		logic [19:0]             lx_f;
		logic signed [31:0]      xr;
		logic signed [31:0]      yr;
		logic [25:0]             n;
		logic signed [42:0]      ap;
		logic signed [9:0]       kx;
		logic [19:0]             f;
		logic [31:0]             acc;
		logic [45:0]             sq_v;
		logic [46:0]             sq_r;
		logic [55:0]             prod;
		logic [31:0]             rad;
		logic [31:0]             b;
		logic                    sat;
		logic signed [64:0]      px_p;
		logic signed [64:0]      py_p;
		logic signed [POS_W-1:0] pos_x;
		logic signed [POS_W-1:0] pos_y;
	} stage_t;

	// Configuration registers.
	logic [1:0]         mode_q;
	logic [23:0]        radius_one_q;
	logic [23:0]        radius_two_q;
	logic [16:0]        fraction_q;
	logic signed [15:0] exponent_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= MODE_SINGLE;
			radius_one_q <= 24'd1048576;
			radius_two_q <= 24'd0;
			fraction_q   <= 17'd65536;
			exponent_q   <= 16'sd0;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_MODE:       mode_q       <= cfg_data[1:0];
				REG_RADIUS_ONE: radius_one_q <= cfg_data[23:0];
				REG_RADIUS_TWO: radius_two_q <= cfg_data[23:0];
				REG_FRACTION:   fraction_q   <= cfg_data[16:0];
				REG_EXPONENT:   exponent_q   <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	stage_t             pipe_s [DEPTH];
	logic [DEPTH-1:0]   pipe_vld_s;
	stage_t             st_in;
	logic               adv;
	logic               buf_full;
	result_t            res_in;
	result_t            res_out;

	logic signed [25:0] in_x;
	logic [UB-1:0]      in_mix;
	logic [UB-1:0]      in_rad;
	logic [UB-1:0]      in_ang;
	logic [24:0]        in_xm;
	logic [37:0]        norm_r;
	logic [37:0]        norm_x;

	assign in_x   = s_tdata[25:0];
	assign in_mix = s_tdata[26 +: UB];
	assign in_rad = s_tdata[26+UB +: UB];
	assign in_ang = s_tdata[26+2*UB +: UB];

	// The pipeline holds only when the output buffer is full.
	assign adv      = !buf_full;
	assign s_tready = adv;

	// First stage: field split, radius choice flags and log2 normalization.
	always_comb begin
		st_in       = '0;
		in_xm       = (in_x[24:0] < X_FLOOR) ? X_FLOOR : in_x[24:0];
		norm_r      = log2_norm(33'(in_rad) + 33'd1);
		norm_x      = log2_norm({8'b0, in_xm});
		st_in.x_ok  = (mode_q == MODE_XDEP) && !in_x[25] && (in_x[24:0] <= 25'h100_0000);
		st_in.sel2  = (mode_q == MODE_DOUBLE) &&
			({1'b0, in_mix, 16'b0} >= {fraction_q, {UB{1'b0}}});
		st_in.umax  = &in_rad;
		st_in.uang  = in_ang;
		st_in.lr_e  = norm_r[37:32];
		st_in.lr_y  = norm_r[31:0];
		st_in.lx_e  = norm_x[37:32];
		st_in.lx_y  = norm_x[31:0];
		st_in.xr    = ONE_Q30;
		st_in.yr    = '0;
	end

	// Valid bits travel with the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pipe_vld_s <= '0;
		end else if (adv) begin
			pipe_vld_s <= {pipe_vld_s[DEPTH-2:0], s_tvalid};
		end
	end

	for (genvar K = 0; K < DEPTH; K++) begin : g_stage
		localparam int RI = (K >= 1 && K <= UB - 2) ? K + 2 : 3;
		localparam int RB = UB - RI;
		localparam int EI = (K >= EXP_FIRST && K <= EXP_LAST) ? K - K_SPLIT : 1;
		localparam int QB = (K >= SQ_FIRST && K <= SQ_LAST) ? 44 - 2*(K - SQ_FIRST) : 0;
		localparam logic signed [31:0] ROT_C  = rot_coef(RI, 1'b0);
		localparam logic signed [31:0] ROT_S  = rot_coef(RI, 1'b1);
		localparam logic [31:0]        EXP_C  = exp2_coef(EI);
		localparam logic [46:0]        SQ_BIT = 47'(1) << QB;

		stage_t             cur;
		stage_t             nxt;
		logic [51:0]        st_r;
		logic [51:0]        st_x;
		logic signed [31:0] rx;
		logic signed [31:0] ry;
		logic [25:0]        l_val;
		logic signed [26:0] lx;
		logic signed [43:0] negp;
		logic signed [43:0] tq;
		logic [46:0]        sq_try;
		logic signed [10:0] sh;
		logic [10:0]        nsh;
		logic [55:0]        shr;
		logic [54:0]        bp;
		logic [25:0]        cx;
		logic [25:0]        cy;

		if (K == 0) begin : g_src
			assign cur = st_in;
		end else begin : g_src
			assign cur = pipe_s[K-1];
		end

		always_comb begin
			nxt    = cur;
			st_r   = '0;
			st_x   = '0;
			rx     = '0;
			ry     = '0;
			l_val  = '0;
			lx     = '0;
			negp   = '0;
			tq     = '0;
			sq_try = '0;
			sh     = '0;
			nsh    = '0;
			shr    = '0;
			bp     = '0;
			cx     = '0;
			cy     = '0;

			// One fraction bit of both logarithms.
			if (K >= 1 && K <= LOG_LAST) begin
				st_r     = log2_step(cur.lr_y, cur.lr_f);
				st_x     = log2_step(cur.lx_y, cur.lx_f);
				nxt.lr_y = st_r[51:20];
				nxt.lr_f = st_r[19:0];
				nxt.lx_y = st_x[51:20];
				nxt.lx_f = st_x[19:0];
			end

			// One fine rotation of the azimuth.
			if (K >= 1 && K <= UB - 2) begin
				if (cur.uang[RB]) begin
					nxt.xr = mul_q30(cur.xr, ROT_C) - mul_q30(cur.yr, ROT_S);
					nxt.yr = mul_q30(cur.xr, ROT_S) + mul_q30(cur.yr, ROT_C);
				end
			end

			// -ln u in Q20 and the exponent product alpha * log2(x).
			if (K == K_PREP) begin
				l_val  = 26'(UB * (1 << 20)) - {cur.lr_e, cur.lr_f};
				nxt.n  = 26'(({32'b0, l_val} * {26'b0, LN2_Q32}) >> 32);
				lx     = $signed({1'b0, cur.lx_e, cur.lx_f}) - 27'sd25165824;
				nxt.ap = 43'(exponent_q) * 43'(lx);
			end

			// Split the radius exponent into whole and fractional parts.
			if (K == K_SPLIT) begin
				negp    = -(44'(cur.ap));
				tq      = negp >>> 14;
				nxt.kx  = tq[29:20];
				nxt.f   = tq[19:0];
				nxt.acc = 32'h8000_0000;
			end

			// One factor of 2^f.
			if (K >= EXP_FIRST && K <= EXP_LAST) begin
				if (cur.f[20 - EI]) begin
					nxt.acc = 32'(({32'b0, cur.acc} * {32'b0, EXP_C}) >> 31);
				end
			end

			// One bit of the square root of -ln u.
			if (K >= SQ_FIRST && K <= SQ_LAST) begin
				if (K == SQ_FIRST) begin
					nxt.sq_v = {cur.n, 20'b0};
					nxt.sq_r = '0;
				end
				sq_try = nxt.sq_r + SQ_BIT;
				if ({1'b0, nxt.sq_v} >= sq_try) begin
					nxt.sq_v = 46'({1'b0, nxt.sq_v} - sq_try);
					nxt.sq_r = (nxt.sq_r >> 1) + SQ_BIT;
				end else begin
					nxt.sq_r = nxt.sq_r >> 1;
				end
			end

			// Radius mantissa product.
			if (K == K_PROD) begin
				nxt.prod = 56'(radius_one_q) * 56'(cur.acc);
			end

			// Radius scaling by 2^k with saturation, then the mode choice.
			if (K == K_RAD) begin
				sh  = 11'(cur.kx) - 11'sd31;
				nsh = 11'(-sh);
				if (!cur.x_ok) begin
					nxt.rad = cur.sel2 ? {8'b0, radius_two_q} : {8'b0, radius_one_q};
				end else if (cur.prod == '0) begin
					nxt.rad = '0;
				end else if (!sh[10]) begin
					if (sh > 11'sd31 ||
							(cur.prod >> (6'd32 - {1'b0, sh[4:0]})) != '0) begin
						nxt.rad = Q20_CAP;
						nxt.sat = 1'b1;
					end else begin
						nxt.rad = 32'(cur.prod << sh[4:0]);
					end
				end else begin
					shr = (nsh >= 11'd64) ? '0 : (cur.prod >> nsh[5:0]);
					if (shr[55:32] != '0) begin
						nxt.rad = Q20_CAP;
						nxt.sat = 1'b1;
					end else begin
						nxt.rad = shr[31:0];
					end
				end
			end

			// Radial distance and the quarter-turn rotation.
			if (K == K_B) begin
				bp = 55'(cur.rad) * 55'(cur.sq_r[22:0]);
				if (bp[54:52] != '0) begin
					nxt.b   = Q20_CAP;
					nxt.sat = 1'b1;
				end else begin
					nxt.b = bp[51:20];
				end
				rx = cur.xr;
				ry = cur.yr;
				case (cur.uang[UB-1:UB-2])
					2'd1: begin
						nxt.xr = -ry;
						nxt.yr = rx;
					end
					2'd2: begin
						nxt.xr = -rx;
						nxt.yr = -ry;
					end
					2'd3: begin
						nxt.xr = ry;
						nxt.yr = -rx;
					end
					default: ;
				endcase
			end

			// Position products.
			if (K == K_MUL) begin
				nxt.px_p = 65'($signed({1'b0, cur.b})) * 65'(cur.xr);
				nxt.py_p = 65'($signed({1'b0, cur.b})) * 65'(cur.yr);
			end

			// Scale, truncate toward zero and clip.
			if (K == K_OUT) begin
				cx        = clip_pos(trunc34(cur.px_p));
				cy        = clip_pos(trunc34(cur.py_p));
				nxt.pos_x = cx[POS_W-1:0];
				nxt.pos_y = cy[POS_W-1:0];
				nxt.sat   = cur.sat | cx[POS_W] | cy[POS_W];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) pipe_s[K] <= nxt;
		end
	end

	assign res_in.pos_x     = pipe_s[DEPTH-1].pos_x;
	assign res_in.pos_y     = pipe_s[DEPTH-1].pos_y;
	assign res_in.saturated = pipe_s[DEPTH-1].sat;

	gpps_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (adv && pipe_vld_s[DEPTH-1]),
		.push_data (res_in),
		.full      (buf_full),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (res_out)
	);

	assign m_tdata = OUT_W'({res_out.pos_y, res_out.pos_x});
	assign m_tuser = res_out.saturated;

	// The fine and quarter rotations never grow either component of the unit vector beyond one.
	assert property (@(posedge clk) disable iff (!arst_n)
		pipe_vld_s[K_B] |-> (pipe_s[K_B].xr <= ONE_Q30) && (pipe_s[K_B].xr >= -ONE_Q30) &&
			(pipe_s[K_B].yr <= ONE_Q30) && (pipe_s[K_B].yr >= -ONE_Q30))
		else $error("rotated vector left the unit range");

	// The largest radial draw means u = 1 and therefore a zero distance.
	assert property (@(posedge clk) disable iff (!arst_n)
		(pipe_vld_s[K_B] && pipe_s[K_B].umax) |-> (pipe_s[K_B].b == '0))
		else $error("largest radial draw gave a nonzero distance");

	// A result is only pushed while the output buffer has room; until then it holds in the last stage.
	assert property (@(posedge clk) disable iff (!arst_n)
		pipe_vld_s[DEPTH-1] && buf_full |=> $stable(pipe_s[DEPTH-1].pos_x) &&
			pipe_vld_s[DEPTH-1])
		else $error("pipeline moved while the output buffer was full");

endmodule
